@@ rtl/hbtd_pkg.sv @@
package hbtd_pkg;

  localparam int COORD_BITS      = 12;
  localparam int ANGLE_FRAC_BITS = 6;
  localparam int ANG_W           = 15;
  localparam int DIFF_W          = ANG_W + 1;
  localparam int DELTA_W         = COORD_BITS + 1;

  // cordic datapath: coordinates shifted up by the guard bits, plus growth and sign
  localparam int CORDIC_GUARD = 16;
  localparam int CW           = COORD_BITS + CORDIC_GUARD + 4;
  localparam int ZSCALE_BITS  = 24;
  localparam int ZW           = 32;
  localparam int TABLE_LEN    = 24;
  localparam int ROUND_SHIFT  = ZSCALE_BITS - ANGLE_FRAC_BITS;

  localparam int DEG     = 1 << ANGLE_FRAC_BITS;
  localparam int QUARTER = 90 * DEG;
  localparam int HALF    = 180 * DEG;
  localparam int THREE_Q = 270 * DEG;
  localparam int FULL    = 360 * DEG;

  // atan(2^-i) in degrees scaled by 2^24
  localparam logic [ZW-1:0] ATAN_TABLE [TABLE_LEN] = '{
    32'd754974720, 32'd445687602, 32'd235489088, 32'd119537938, 32'd60000934,
    32'd30029717,  32'd15018523,  32'd7509720,   32'd3754917,   32'd1877466,
    32'd938734,    32'd469367,    32'd234684,    32'd117342,    32'd58671,
    32'd29335,     32'd14668,     32'd7334,      32'd3667,      32'd1833,
    32'd917,       32'd458,       32'd229,       32'd115
  };

  typedef enum logic [1:0] {
    TURN_ALIGNED = 2'd0,
    TURN_CW      = 2'd1,
    TURN_CCW     = 2'd2
  } turn_e;

  typedef struct packed {
    logic [COORD_BITS-1:0] front_tag_x;
    logic [COORD_BITS-1:0] front_tag_y;
    logic [COORD_BITS-1:0] rear_tag_x;
    logic [COORD_BITS-1:0] rear_tag_y;
    logic [COORD_BITS-1:0] target_x;
    logic [COORD_BITS-1:0] target_y;
  } hbtd_in_t;

  typedef struct packed {
    logic [ANG_W-1:0]         heading_angle;
    logic [ANG_W-1:0]         bearing_angle;
    logic signed [DIFF_W-1:0] angle_difference;
    logic [1:0]               turn_direction;
  } hbtd_out_t;

endpackage

@@ rtl/heading_bearing_turn_decider_unit.sv @@
// pipeline: prep register, cordic stages, round stage, quad stage, output register
// throughput: one beat per cycle while out_stall_i is low, set by one cordic iteration per pipeline stage
// both vectors run through their own cordic lanes side by side
// reset clears every stage valid bit; payload registers are not reset
module heading_bearing_turn_decider_unit #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  hbtd_pkg::hbtd_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output hbtd_pkg::hbtd_out_t out_data_o
);
  import hbtd_pkg::*;

  localparam int NST     = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;
  localparam int ROUND_S = NST + 1;
  localparam int QUAD_S  = NST + 2;
  localparam int OUT_S   = NST + 3;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 special;
    logic [ANG_W-1:0]     angle;
    logic                 dx_neg;
    logic                 dy_neg;
  } vec_t;

  function automatic vec_t prep_vec(logic [COORD_BITS-1:0] px, logic [COORD_BITS-1:0] py,
                                    logic [COORD_BITS-1:0] ox, logic [COORD_BITS-1:0] oy);
    vec_t                      r;
    logic signed [DELTA_W-1:0] dx;
    logic signed [DELTA_W-1:0] dy;
    logic [DELTA_W-1:0]        ax;
    logic [DELTA_W-1:0]        ay;
    // image rows grow downward, so the y axis is flipped
    dx = $signed({1'b0, px}) - $signed({1'b0, ox});
    dy = $signed({1'b0, oy}) - $signed({1'b0, py});
    ax = dx[DELTA_W-1] ? DELTA_W'(-dx) : DELTA_W'(dx);
    ay = dy[DELTA_W-1] ? DELTA_W'(-dy) : DELTA_W'(dy);
    r.x      = $signed(CW'(ax) << CORDIC_GUARD);
    r.y      = $signed(CW'(ay) << CORDIC_GUARD);
    r.z      = '0;
    r.dx_neg = dx[DELTA_W-1];
    r.dy_neg = dy[DELTA_W-1];
    r.special = (dx == '0) || (dy == '0);
    if (dx == '0 && dy == '0) begin
      r.angle = '0;
    end else if (dx == '0) begin
      r.angle = dy[DELTA_W-1] ? ANG_W'(THREE_Q) : ANG_W'(QUARTER);
    end else if (dy == '0) begin
      r.angle = dx[DELTA_W-1] ? ANG_W'(HALF) : '0;
    end else begin
      r.angle = '0;
    end
    return r;
  endfunction

  // arithmetic shift that truncates toward zero
  function automatic logic signed [CW-1:0] shr_tz(logic signed [CW-1:0] v, int s);
    logic signed [CW-1:0] bias;
    bias = v[CW-1] ? $signed((CW'(1) << s) - CW'(1)) : '0;
    return (v + bias) >>> s;
  endfunction

  function automatic vec_t cordic_step(vec_t v, int s);
    vec_t                 r;
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    r  = v;
    xs = shr_tz(v.x, s);
    ys = shr_tz(v.y, s);
    if (!v.y[CW-1]) begin
      r.x = v.x + ys;
      r.y = v.y - xs;
      r.z = v.z + $signed(ATAN_TABLE[s]);
    end else begin
      r.x = v.x - ys;
      r.y = v.y + xs;
      r.z = v.z - $signed(ATAN_TABLE[s]);
    end
    return r;
  endfunction

  function automatic vec_t round_step(vec_t v);
    vec_t          r;
    logic [ZW-1:0] zp;
    logic [ZW-1:0] a;
    r  = v;
    zp = v.z[ZW-1] ? '0 : ZW'(v.z);
    a  = (zp + (ZW'(1) << (ROUND_SHIFT - 1))) >> ROUND_SHIFT;
    if (a > ZW'(QUARTER)) begin
      a = ZW'(QUARTER);
    end
    if (!v.special) begin
      r.angle = ANG_W'(a);
    end
    return r;
  endfunction

  function automatic vec_t quad_step(vec_t v);
    vec_t r;
    r = v;
    if (!v.special) begin
      case ({v.dx_neg, v.dy_neg})
        2'b00:   r.angle = v.angle;
        2'b10:   r.angle = ANG_W'(HALF) - v.angle;
        2'b11:   r.angle = ANG_W'(HALF) + v.angle;
        default: r.angle = (v.angle == '0) ? '0 : ANG_W'(FULL) - v.angle;
      endcase
    end
    return r;
  endfunction

  logic [OUT_S:0]   valid_q;
  logic [OUT_S:0]   valid_src;
  logic [OUT_S+1:0] rdy;
  vec_t             vec_q [QUAD_S+1][2];
  hbtd_out_t        out_q;
  hbtd_out_t        out_d;

  // a stage takes a beat when it is empty or its own beat moves on
  assign rdy[OUT_S+1] = !out_stall_i;
  for (genvar k = 0; k <= OUT_S; k++) begin : g_rdy
    assign rdy[k] = !valid_q[k] || rdy[k+1];
  end

  assign valid_src  = {valid_q[OUT_S-1:0], in_valid_i};
  assign in_stall_o = !rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      for (int k = 0; k <= OUT_S; k++) begin
        if (rdy[k]) begin
          valid_q[k] <= valid_src[k];
        end
      end
    end
  end

  always_comb begin
    logic [ANG_W-1:0]         h;
    logic [ANG_W-1:0]         b;
    logic signed [DIFF_W-1:0] diff;
    logic                     short_way;
    h    = vec_q[QUAD_S][0].angle;
    b    = vec_q[QUAD_S][1].angle;
    diff = $signed({1'b0, h}) - $signed({1'b0, b});
    short_way = (diff <= $signed(DIFF_W'(HALF))) && (diff >= -$signed(DIFF_W'(HALF)));
    out_d.heading_angle    = h;
    out_d.bearing_angle    = b;
    out_d.angle_difference = diff;
    if (diff == '0) begin
      out_d.turn_direction = TURN_ALIGNED;
    end else if (short_way) begin
      out_d.turn_direction = diff[DIFF_W-1] ? TURN_CCW : TURN_CW;
    end else begin
      out_d.turn_direction = diff[DIFF_W-1] ? TURN_CW : TURN_CCW;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0] && in_valid_i) begin
      vec_q[0][0] <= prep_vec(in_data_i.front_tag_x, in_data_i.front_tag_y,
                              in_data_i.rear_tag_x, in_data_i.rear_tag_y);
      vec_q[0][1] <= prep_vec(in_data_i.target_x, in_data_i.target_y,
                              in_data_i.rear_tag_x, in_data_i.rear_tag_y);
    end
    for (int k = 0; k < NST; k++) begin
      if (rdy[k+1] && valid_q[k]) begin
        vec_q[k+1][0] <= cordic_step(vec_q[k][0], k);
        vec_q[k+1][1] <= cordic_step(vec_q[k][1], k);
      end
    end
    if (rdy[ROUND_S] && valid_q[NST]) begin
      vec_q[ROUND_S][0] <= round_step(vec_q[NST][0]);
      vec_q[ROUND_S][1] <= round_step(vec_q[NST][1]);
    end
    if (rdy[QUAD_S] && valid_q[ROUND_S]) begin
      vec_q[QUAD_S][0] <= quad_step(vec_q[ROUND_S][0]);
      vec_q[QUAD_S][1] <= quad_step(vec_q[ROUND_S][1]);
    end
    if (rdy[OUT_S] && valid_q[QUAD_S]) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = valid_q[OUT_S];
  assign out_data_o  = out_q;

endmodule
